FILE: src/ddar_pkg.sv
package ddar_pkg;

  localparam int COORD_BITS  = 6;
  localparam int DASH_LEN_W  = 6;
  localparam int DASH_CNT_W  = 7;
  localparam int COLOR_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_DASH_LENGTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COLOR = CFG_INDEX_W'(1);

  localparam logic [DASH_LEN_W-1:0] DASH_LENGTH_RST = DASH_LEN_W'(3);
  localparam logic [COLOR_W-1:0]    PIXEL_COLOR_RST = COLOR_W'(15);

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pen_down;
    logic [COLOR_W-1:0]    color_out;
    logic                  last;
  } out_item_t;

  // classified line command passed from front to back
  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] step;
    logic                  x_neg;
    logic                  y_neg;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WALK
  } back_state_t;

endpackage

FILE: src/dashed_dda_line_rasterizer.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_item   (line start and end point)
// out      output     out_valid/out_ready  out_item  (one position of the line)
// cfg      input      cfg_we               cfg_index, cfg_wdata (no read-back)
//
// a line of step = max(|dx|,|dy|) is drawn in order: the command is pulled from
// the queue, the divider is started, the shared radix-2 divider yields both
// increments to FRAC_BITS+1 quotient bits, the walker is loaded, then it gives
// one position a cycle (step+1 of them) while the output register is free or
// out_ready is high. reset is synchronous, active low; it empties the queue and
// restores the dash length and color. the queue keeps taking commands while the
// walker runs, and out_ready low only freezes the walker and its output register
module dashed_dda_line_rasterizer
  import ddar_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int GAP_LENGTH  = 5,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [DASH_LEN_W-1:0] dash_length_r, dash_length_nxt;
  logic [COLOR_W-1:0]    pixel_color_r, pixel_color_nxt;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // config registers, writes to unknown indexes fall through
  always_comb begin
    dash_length_nxt = dash_length_r;
    pixel_color_nxt = pixel_color_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DASH_LENGTH: dash_length_nxt = cfg_wdata[DASH_LEN_W-1:0];
        CFG_PIXEL_COLOR: pixel_color_nxt = cfg_wdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_length_r <= DASH_LENGTH_RST;
      pixel_color_r <= PIXEL_COLOR_RST;
    end else begin
      dash_length_r <= dash_length_nxt;
      pixel_color_r <= pixel_color_nxt;
    end
  end

  // front: deltas, direction and step count of each command
  ddar_front u_front (
    .in_item (in_item),
    .cmd     (front_cmd)
  );

  // short queue decouples command intake from the walker
  ddar_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (queue_cmd),
    .empty     (q_empty)
  );

  assign in_ready = !q_full;

  // back: increment division, then the dashed walk
  ddar_back #(
    .FRAC_BITS  (FRAC_BITS),
    .GAP_LENGTH (GAP_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (queue_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .dash_length (dash_length_r),
    .pixel_color (pixel_color_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule

FILE: src/ddar_front.sv
module ddar_front
  import ddar_pkg::*;
(
  input  in_item_t in_item,
  output cmd_t     cmd
);

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  x_neg;
  logic                  y_neg;

  assign x_neg = in_item.x_end < in_item.x_start;
  assign y_neg = in_item.y_end < in_item.y_start;
  assign adx   = x_neg ? in_item.x_start - in_item.x_end : in_item.x_end - in_item.x_start;
  assign ady   = y_neg ? in_item.y_start - in_item.y_end : in_item.y_end - in_item.y_start;

  always_comb begin
    cmd.x_start = in_item.x_start;
    cmd.y_start = in_item.y_start;
    cmd.adx     = adx;
    cmd.ady     = ady;
    cmd.step    = (adx > ady) ? adx : ady;
    cmd.x_neg   = x_neg;
    cmd.y_neg   = y_neg;
  end

endmodule

FILE: src/ddar_fifo.sv
module ddar_fifo
  import ddar_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/ddar_div.sv
module ddar_div
  import ddar_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] adx,
  input  logic [COORD_BITS-1:0] ady,
  input  logic [COORD_BITS-1:0] step,
  input  logic                  x_neg,
  input  logic                  y_neg,
  output logic                  done,
  output logic [FRAC_BITS+1:0]  x_inc,
  output logic [FRAC_BITS+1:0]  y_inc
);

  localparam int INC_W = FRAC_BITS + 2;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int NW    = $clog2(Q_W);

  // remainders are kept pre-shifted for the next quotient bit
  logic [COORD_BITS:0]   x_rem_r, x_rem_nxt;
  logic [COORD_BITS:0]   y_rem_r, y_rem_nxt;
  logic [Q_W-1:0]        x_q_r, x_q_nxt;
  logic [Q_W-1:0]        y_q_r, y_q_nxt;
  logic [NW-1:0]         cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [COORD_BITS:0]   divisor;
  logic                  x_ge, y_ge;
  logic [COORD_BITS:0]   x_diff, y_diff;
  logic [COORD_BITS-1:0] x_left, y_left;
  logic [INC_W-1:0]      x_mag, y_mag;

  assign divisor = {1'b0, step};
  assign x_ge    = x_rem_r >= divisor;
  assign y_ge    = y_rem_r >= divisor;
  assign x_diff  = x_rem_r - divisor;
  assign y_diff  = y_rem_r - divisor;
  assign x_left  = x_ge ? x_diff[COORD_BITS-1:0] : x_rem_r[COORD_BITS-1:0];
  assign y_left  = y_ge ? y_diff[COORD_BITS-1:0] : y_rem_r[COORD_BITS-1:0];

  always_comb begin
    x_rem_nxt = x_rem_r;
    y_rem_nxt = y_rem_r;
    x_q_nxt   = x_q_r;
    y_q_nxt   = y_q_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    if (start) begin
      x_rem_nxt = {1'b0, adx};
      y_rem_nxt = {1'b0, ady};
      x_q_nxt   = '0;
      y_q_nxt   = '0;
      cnt_nxt   = '0;
      run_nxt   = 1'b1;
    end else if (run_r) begin
      x_rem_nxt = {x_left, 1'b0};
      y_rem_nxt = {y_left, 1'b0};
      x_q_nxt   = {x_q_r[Q_W-2:0], x_ge};
      y_q_nxt   = {y_q_r[Q_W-2:0], y_ge};
      cnt_nxt   = cnt_r + NW'(1);
      if (cnt_r == NW'(Q_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_rem_r <= x_rem_nxt;
    y_rem_r <= y_rem_nxt;
    x_q_r   <= x_q_nxt;
    y_q_r   <= y_q_nxt;
  end

  // zero-length line gets zero increments
  assign x_mag = (step == '0) ? '0 : {1'b0, x_q_r};
  assign y_mag = (step == '0) ? '0 : {1'b0, y_q_r};
  assign x_inc = x_neg ? INC_W'(0) - x_mag : x_mag;
  assign y_inc = y_neg ? INC_W'(0) - y_mag : y_mag;
  assign done  = done_r;

endmodule

FILE: src/ddar_back.sv
module ddar_back
  import ddar_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int GAP_LENGTH = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [DASH_LEN_W-1:0] dash_length,
  input  logic [COLOR_W-1:0]    pixel_color,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W = FRAC_BITS + 2;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  back_state_t           state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ACC_W-1:0]      x_acc_r, x_acc_nxt;
  logic [ACC_W-1:0]      y_acc_r, y_acc_nxt;
  logic [INC_W-1:0]      x_inc_r, x_inc_nxt;
  logic [INC_W-1:0]      y_inc_r, y_inc_nxt;
  logic [COORD_BITS-1:0] steps_r, steps_nxt;
  logic [DASH_CNT_W-1:0] dash_r, dash_nxt;
  logic                  pen_r, pen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;
  // kick the divider in the cycle after the command is taken from the queue
  logic                  start_r;

  logic                  div_done;
  logic [INC_W-1:0]      div_x_inc, div_y_inc;
  logic                  fire;
  logic [ACC_W-1:0]      x_round, y_round;
  logic [DASH_CNT_W-1:0] lim, lim_gap;
  logic                  in_gap, gap_end;

  ddar_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .adx   (cmd_r.adx),
    .ady   (cmd_r.ady),
    .step  (cmd_r.step),
    .x_neg (cmd_r.x_neg),
    .y_neg (cmd_r.y_neg),
    .done  (div_done),
    .x_inc (div_x_inc),
    .y_inc (div_y_inc)
  );

  assign fire    = (state_r == BK_WALK) && (!out_valid_r || out_ready);
  assign x_round = x_acc_r + HALF;
  assign y_round = y_acc_r + HALF;
  assign lim     = {1'b0, dash_length};
  assign lim_gap = lim + DASH_CNT_W'(GAP_LENGTH);
  assign in_gap  = (dash_r > lim) && (dash_r < lim_gap);
  assign gap_end = dash_r == lim_gap;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    x_inc_nxt     = x_inc_r;
    y_inc_nxt     = y_inc_r;
    steps_nxt     = steps_r;
    dash_nxt      = dash_r;
    pen_nxt       = pen_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        // the divider starts on the first cycle here, then signals done
        if (div_done) begin
          x_acc_nxt = ACC_W'({cmd_r.x_start, {FRAC_BITS{1'b0}}});
          y_acc_nxt = ACC_W'({cmd_r.y_start, {FRAC_BITS{1'b0}}});
          x_inc_nxt = div_x_inc;
          y_inc_nxt = div_y_inc;
          steps_nxt = cmd_r.step;
          dash_nxt  = '0;
          pen_nxt   = 1'b1;
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        if (fire) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.pixel_x   = x_round[FRAC_BITS +: COORD_BITS];
          out_item_nxt.pixel_y   = y_round[FRAC_BITS +: COORD_BITS];
          out_item_nxt.pen_down  = pen_r;
          out_item_nxt.color_out = pen_r ? pixel_color : '0;
          out_item_nxt.last      = steps_r == '0;
          if (steps_r == '0) begin
            state_nxt = BK_IDLE;
          end else begin
            steps_nxt = steps_r - COORD_BITS'(1);
            x_acc_nxt = x_acc_r + {{(ACC_W - INC_W){x_inc_r[INC_W-1]}}, x_inc_r};
            y_acc_nxt = y_acc_r + {{(ACC_W - INC_W){y_inc_r[INC_W-1]}}, y_inc_r};
            if (in_gap) begin
              dash_nxt = dash_r + DASH_CNT_W'(1);
              pen_nxt  = 1'b0;
            end else if (gap_end) begin
              dash_nxt = '0;
              pen_nxt  = 1'b0;
            end else begin
              dash_nxt = dash_r + DASH_CNT_W'(1);
              pen_nxt  = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    x_acc_r    <= x_acc_nxt;
    y_acc_r    <= y_acc_nxt;
    x_inc_r    <= x_inc_nxt;
    y_inc_r    <= y_inc_nxt;
    steps_r    <= steps_nxt;
    dash_r     <= dash_nxt;
    pen_r      <= pen_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: bench/dda_line_checker.sv
`timescale 1ns / 1ps

module dda_line_checker
  import ddar_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int GAP_LENGTH = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned            error_count,
  output int unsigned            pending
);

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int INC_W = FRAC_BITS + 2;

  logic [DASH_LEN_W-1:0] dash_len_q;
  logic [COLOR_W-1:0]    color_q;
  out_item_t             pixel_q[$];
  out_item_t             want;
  int unsigned           errs = 0;

  // signed per-step slope, magnitude truncated toward zero
  function automatic logic [INC_W-1:0] slope(input logic [COORD_BITS-1:0] from,
                                             input logic [COORD_BITS-1:0] to,
                                             input logic [COORD_BITS-1:0] span);
    logic [COORD_BITS-1:0]           delta;
    logic [COORD_BITS+FRAC_BITS-1:0] num;
    logic [INC_W-1:0]                mag;
    delta = (to < from) ? from - to : to - from;
    if (span == '0) return '0;
    num = {delta, {FRAC_BITS{1'b0}}};
    mag = INC_W'(num / span);
    return (to < from) ? -mag : mag;
  endfunction

  // round half up to a pixel coordinate
  function automatic logic [COORD_BITS-1:0] to_pixel(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sum;
    sum = acc + (ACC_W'(1) << (FRAC_BITS - 1));
    return sum[FRAC_BITS +: COORD_BITS];
  endfunction

  // queue every position of one line command
  function automatic void walk_line(input in_item_t cmd);
    logic [COORD_BITS-1:0] adx, ady, span;
    logic [INC_W-1:0]      x_inc, y_inc;
    logic [ACC_W-1:0]      x_acc, y_acc;
    logic [DASH_CNT_W-1:0] dash;
    logic                  pen;
    out_item_t             pix;
    adx   = (cmd.x_end > cmd.x_start) ? cmd.x_end - cmd.x_start : cmd.x_start - cmd.x_end;
    ady   = (cmd.y_end > cmd.y_start) ? cmd.y_end - cmd.y_start : cmd.y_start - cmd.y_end;
    span  = (adx > ady) ? adx : ady;
    x_inc = slope(cmd.x_start, cmd.x_end, span);
    y_inc = slope(cmd.y_start, cmd.y_end, span);
    x_acc = {1'b0, cmd.x_start, {FRAC_BITS{1'b0}}};
    y_acc = {1'b0, cmd.y_start, {FRAC_BITS{1'b0}}};
    dash  = '0;
    pix   = '{to_pixel(x_acc), to_pixel(y_acc), 1'b1, color_q, span == '0};
    pixel_q.push_back(pix);
    for (int k = 1; k <= int'(span); k++) begin
      x_acc = x_acc + {{(ACC_W-INC_W){x_inc[INC_W-1]}}, x_inc};
      y_acc = y_acc + {{(ACC_W-INC_W){y_inc[INC_W-1]}}, y_inc};
      if (dash > dash_len_q && int'(dash) < int'(dash_len_q) + GAP_LENGTH) begin
        dash++;
        pen = 1'b0;
      end else if (int'(dash) == int'(dash_len_q) + GAP_LENGTH) begin
        dash = '0;
        pen  = 1'b0;
      end else begin
        dash++;
        pen = 1'b1;
      end
      pix = '{to_pixel(x_acc), to_pixel(y_acc), pen, pen ? color_q : '0, k == int'(span)};
      pixel_q.push_back(pix);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dash_len_q = DASH_LENGTH_RST;
      color_q    = PIXEL_COLOR_RST;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DASH_LENGTH) dash_len_q = cfg_wdata[DASH_LEN_W-1:0];
        else if (cfg_index == CFG_PIXEL_COLOR) color_q = cfg_wdata[COLOR_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: pixel with no line pending: x=%0d y=%0d pen=%0b color=%0d last=%0b",
                     $realtime, out_item.pixel_x, out_item.pixel_y, out_item.pen_down,
                     out_item.color_out, out_item.last);
        end else begin
          want = pixel_q.pop_front();
          if (out_item.pixel_x !== want.pixel_x || out_item.pixel_y !== want.pixel_y ||
              out_item.pen_down !== want.pen_down || out_item.color_out !== want.color_out ||
              out_item.last !== want.last) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: pixel mismatch: expected x=%0d y=%0d pen=%0b color=%0d last=%0b,",
                        " got x=%0d y=%0d pen=%0b color=%0d last=%0b"}, $realtime,
                       want.pixel_x, want.pixel_y, want.pen_down, want.color_out, want.last,
                       out_item.pixel_x, out_item.pixel_y, out_item.pen_down,
                       out_item.color_out, out_item.last);
          end
        end
      end
      if (in_valid && in_ready) walk_line(in_item);
    end
    error_count <= errs;
    pending     <= pixel_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ddar_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int GAP_LENGTH  = 5;
  localparam int CYCLE_LIMIT = 1_000_000;
  // settle time after the last pixel: divider plus the longest walk
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 8;
  localparam int LINES_PER_PHASE = 31;

  // register indexes the block decodes to nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

  // how the result side paces itself
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_item;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  int unsigned            error_count;
  int unsigned            pending;
  int unsigned            cycles = 0;
  int                     burst_left;
  bit                     steady;

  // corner cases: zero length at both corners, full-length axis lines in both
  // directions, all four diagonals, nearly flat and nearly steep lines, exact
  // half-pixel positions going up and down, and a few ordinary lines
  in_item_t edge_lines [20] = '{
    '{0, 0, 0, 0},    '{63, 63, 63, 63},
    '{0, 0, 63, 0},   '{63, 0, 0, 0},    '{0, 0, 0, 63},   '{0, 63, 0, 0},
    '{0, 0, 63, 63},  '{63, 63, 0, 0},   '{0, 63, 63, 0},  '{63, 0, 0, 63},
    '{0, 0, 63, 1},   '{0, 0, 1, 63},    '{63, 62, 0, 63},
    '{0, 0, 2, 1},    '{0, 1, 2, 0},     '{0, 0, 4, 1},
    '{10, 10, 11, 10}, '{5, 10, 40, 27}, '{40, 27, 5, 10}, '{21, 42, 42, 21}
  };

  dashed_dda_line_rasterizer #(
    .FRAC_BITS (FRAC_BITS),
    .GAP_LENGTH(GAP_LENGTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // prediction and comparison live in the checker
  dda_line_checker #(
    .FRAC_BITS (FRAC_BITS),
    .GAP_LENGTH(GAP_LENGTH)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .error_count(error_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: open, random, or long stalls with short windows, each for a while
  initial begin : sink
    sink_mode_t mode;
    int         span;
    int         hold;
    logic       lvl;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = sink_mode_t'($urandom_range(0, 2));
      span = $urandom_range(20, 150);
      hold = 0;
      lvl  = 1'b1;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          SINK_OPEN: out_ready = 1'b1;
          SINK_RANDOM: out_ready = ($urandom_range(0, 3) != 0);
          default: begin
            if (hold == 0) begin
              lvl  = !lvl;
              hold = lvl ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            hold--;
            out_ready = lvl;
          end
        endcase
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    return COORD_BITS'((v < 0) ? 0 : ((v > 63) ? 63 : v));
  endfunction

  // mostly free lines, then short ones, axis and diagonal ones, and points
  function automatic in_item_t random_line();
    in_item_t cmd;
    int       pick;
    int       d;
    pick        = $urandom_range(0, 99);
    cmd.x_start = COORD_BITS'($urandom_range(0, 63));
    cmd.y_start = COORD_BITS'($urandom_range(0, 63));
    cmd.x_end   = COORD_BITS'($urandom_range(0, 63));
    cmd.y_end   = COORD_BITS'($urandom_range(0, 63));
    if (pick >= 60 && pick < 85) begin
      cmd.x_end = clamp_coord(int'(cmd.x_start) + $urandom_range(0, 8) - 4);
      cmd.y_end = clamp_coord(int'(cmd.y_start) + $urandom_range(0, 8) - 4);
    end else if (pick >= 85 && pick < 93) begin
      d = $urandom_range(1, 63);
      case ($urandom_range(0, 2))
        0: cmd.y_end = cmd.y_start;
        1: cmd.x_end = cmd.x_start;
        default: begin
          cmd.x_end = clamp_coord(int'(cmd.x_start) + ($urandom_range(0, 1) ? d : -d));
          cmd.y_end = clamp_coord(int'(cmd.y_start) + ($urandom_range(0, 1) ? d : -d));
        end
      endcase
    end else if (pick >= 93) begin
      cmd.x_end = cmd.x_start;
      cmd.y_end = cmd.y_start;
    end
    return cmd;
  endfunction

  // offer one line at a falling edge and hold it until taken
  task automatic send_line(input in_item_t cmd);
    int gap;
    in_valid = 1'b1;
    in_item  = cmd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // end of a burst: drop valid for a random gap unless this phase runs flat out
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = steady ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // hold still until every predicted pixel has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] dash_w;
    logic [CFG_DATA_W-1:0] color_w;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_DASH_LENGTH;
    cfg_wdata  = '0;
    burst_left = 1;
    steady     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed lines under the reset dash length and color
    foreach (edge_lines[i]) send_line(edge_lines[i]);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      // extremes first: the shortest dash with color bits above the field set,
      // then the longest dash and full white, then random settings
      case (p)
        0: begin
          dash_w  = '0;
          color_w = 6'b110000;
        end
        1: begin
          dash_w  = 6'd63;
          color_w = 6'b001111;
        end
        default: begin
          dash_w  = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 8))
                                         : CFG_DATA_W'($urandom_range(0, 63));
          color_w = CFG_DATA_W'($urandom_range(0, 63));
        end
      endcase
      write_reg(CFG_DASH_LENGTH, dash_w);
      write_reg(CFG_PIXEL_COLOR, color_w);
      // unused indexes must leave both registers alone
      if (p == 2 || p == 5) begin
        write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(0, 63)));
        write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(0, 63)));
      end
      cfg_we = 1'b0;
      steady = (p % 3 == 2);
      repeat (LINES_PER_PHASE) send_line(random_line());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ddar_pkg.sv
src/ddar_front.sv
src/ddar_fifo.sv
src/ddar_div.sv
src/ddar_back.sv
src/dashed_dda_line_rasterizer.sv
bench/dda_line_checker.sv
bench/tb_top.sv
